/* hdl/svg_pkg.sv */
// ---------------------------------------------------------------------------
// svg_pkg
// Shared constants, types and helpers for the station visibility geometry
// pipeline: sine series divisors, register indexes and reset values.
// ---------------------------------------------------------------------------
package svg_pkg;

  localparam int SIN_STEPS = 7;
  localparam int SIN_LAT   = 4 + 3 * SIN_STEPS;
  localparam int FRONT_LAT = 3;
  localparam int GEO_LAT   = 12;
  localparam int TOTAL_LAT = FRONT_LAT + SIN_LAT + GEO_LAT;
  localparam int NUM_ANG   = 9;

  localparam logic [31:0] QTR_TURN  = 32'h4000_0000;
  localparam logic [31:0] RAD_SCALE = 32'd3373259426;
  localparam logic [30:0] ONE_Q30   = 31'h4000_0000;

  localparam logic signed [34:0] Q30_POS = 35'sd1073741824;
  localparam logic signed [34:0] Q30_NEG = -35'sd1073741824;
  localparam logic signed [26:0] POS_HI  = 27'sd16777215;
  localparam logic signed [26:0] POS_LO  = -27'sd16777216;

  localparam logic [7:0]  SIN_DIV [SIN_STEPS] = '{
    8'd210, 8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6
  };
  localparam logic [32:0] SIN_MUL [SIN_STEPS] = '{
    33'd5235769656, 33'd7048151460, 33'd4997780126, 33'd7635497415,
    33'd6544712070, 33'd6871947673, 33'd5726623061
  };
  localparam int SIN_SHF [SIN_STEPS] = '{40, 40, 39, 39, 38, 37, 35};

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_MOON_INC   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOON_PHASE = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOON_RATE  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EARTH_RATE = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MOON_DIST  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_EARTH_RAD  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_MOON_RAD   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_ELEV   = 4'd7;

  localparam logic [31:0] RST_MOON_INC   = 32'd61382000;
  localparam logic [31:0] RST_MOON_PHASE = 32'd0;
  localparam logic [31:0] RST_MOON_RATE  = 32'd6550000;
  localparam logic [31:0] RST_EARTH_RATE = 32'd179400000;
  localparam logic [23:0] RST_MOON_DIST  = 24'd6150400;
  localparam logic [23:0] RST_EARTH_RAD  = 24'd101936;
  localparam logic [23:0] RST_MOON_RAD   = 24'd27798;
  localparam logic [31:0] RST_MIN_ELEV   = 32'd0;

  typedef struct packed {
    logic signed [31:0] ca;
    logic signed [31:0] sa;
    logic signed [31:0] ci;
    logic signed [31:0] si;
    logic signed [31:0] cl;
    logic signed [31:0] sl;
    logic signed [31:0] cx;
    logic signed [31:0] sx;
    logic signed [31:0] sm;
  } trig_t;

  function automatic logic signed [31:0] clamp_q30(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > Q30_POS) begin
      r = 32'(Q30_POS);
    end else if (v < Q30_NEG) begin
      r = 32'(Q30_NEG);
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [24:0] sat_pos(input logic signed [26:0] v);
    logic [24:0] r;
    if (v > POS_HI) begin
      r = 25'(POS_HI);
    end else if (v < POS_LO) begin
      r = 25'(POS_LO);
    end else begin
      r = v[24:0];
    end
    return r;
  endfunction

endpackage

/* hdl/svg_sin_step.sv */
// ---------------------------------------------------------------------------
// svg_sin_step
// One term of the sine series: p' = 1 - (u * p) / k, three register stages,
// division by the constant k done by reciprocal multiply and one correction.
// ---------------------------------------------------------------------------
module svg_sin_step import svg_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic        clk,
  input  logic [31:0] u_i,
  input  logic [30:0] p_i,
  output logic [31:0] u_o,
  output logic [30:0] p_o
);

  localparam logic [7:0]  K = SIN_DIV[IDX];
  localparam logic [32:0] M = SIN_MUL[IDX];
  localparam int          S = SIN_SHF[IDX];

  logic [62:0] prod_a;
  logic [64:0] prod_b;
  logic [39:0] qk;
  logic [39:0] rem;
  logic [31:0] quo;

  logic [31:0] v_a_r, u_a_r;
  logic [31:0] q0_r, v_b_r, u_b_r;
  logic [30:0] p_r;
  logic [31:0] u_c_r;

  assign prod_a = 63'(u_i) * 63'(p_i);
  assign prod_b = 65'(v_a_r) * 65'(M);
  assign qk     = 40'(q0_r) * 40'(K);
  assign rem    = 40'(v_b_r) - qk;
  assign quo    = q0_r + 32'(rem >= 40'(K));

  always_ff @(posedge clk) begin
    v_a_r <= prod_a[61:30];
    u_a_r <= u_i;
    q0_r  <= 32'(prod_b >> S);
    v_b_r <= v_a_r;
    u_b_r <= u_a_r;
    p_r   <= 31'(32'(ONE_Q30) - quo);
    u_c_r <= u_b_r;
  end

  assign u_o = u_c_r;
  assign p_o = p_r;

endmodule

/* hdl/svg_sin.sv */
// ---------------------------------------------------------------------------
// svg_sin
// Pipelined sine of a 2^-32 turn angle, Q1.30 result. Quadrant fold,
// radian scaling, seven series terms, final product, clamp and sign.
// ---------------------------------------------------------------------------
module svg_sin import svg_pkg::*; (
  input  logic               clk,
  input  logic [31:0]        ang_i,
  output logic signed [31:0] y_o
);

  localparam int DLY = 2 + 3 * SIN_STEPS;

  logic [30:0] rr;
  logic [62:0] prod_t;
  logic [61:0] prod_u;
  logic [61:0] prod_f;
  logic signed [31:0] fc;

  logic [30:0] t_d   [DLY];
  logic        neg_d [DLY+1];
  logic [31:0] u_r;
  logic [30:0] f_r;
  logic signed [31:0] y_r;

  logic [31:0] u_s [SIN_STEPS];
  logic [30:0] p_s [SIN_STEPS+1];

  assign rr     = ang_i[30] ? (ONE_Q30 - {1'b0, ang_i[29:0]}) : {1'b0, ang_i[29:0]};
  assign prod_t = 63'(rr) * 63'(RAD_SCALE);
  assign prod_u = 62'(t_d[0]) * 62'(t_d[0]);
  assign prod_f = 62'(t_d[DLY-1]) * 62'(p_s[SIN_STEPS]);
  assign fc     = (f_r > ONE_Q30) ? 32'(ONE_Q30) : 32'(f_r);

  always_ff @(posedge clk) begin
    t_d[0]   <= prod_t[61:31];
    neg_d[0] <= ang_i[31];
    for (int i = 1; i < DLY; i++) begin
      t_d[i] <= t_d[i-1];
    end
    for (int i = 1; i <= DLY; i++) begin
      neg_d[i] <= neg_d[i-1];
    end
    u_r <= prod_u[61:30];
    f_r <= prod_f[60:30];
    y_r <= neg_d[DLY] ? -fc : fc;
  end

  assign u_s[0] = u_r;
  assign p_s[0] = ONE_Q30;

  for (genvar g = 0; g < SIN_STEPS; g++) begin : g_step
    if (g < SIN_STEPS - 1) begin : g_mid
      svg_sin_step #(.IDX(g)) u_step (
        .clk (clk),
        .u_i (u_s[g]),
        .p_i (p_s[g]),
        .u_o (u_s[g+1]),
        .p_o (p_s[g+1])
      );
    end else begin : g_last
      svg_sin_step #(.IDX(g)) u_step (
        .clk (clk),
        .u_i (u_s[g]),
        .p_i (p_s[g]),
        .u_o (),
        .p_o (p_s[g+1])
      );
    end
  end

  assign y_o = y_r;

endmodule

/* hdl/svg_geo.sv */
// ---------------------------------------------------------------------------
// svg_geo
// Vector datapath: Moon frame, station up vector and position, elevation
// dot product and ray-sphere occultation test, twelve register stages.
// ---------------------------------------------------------------------------
module svg_geo import svg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               vld_i,
  input  trig_t              trig_i,
  input  logic               body_i,
  input  logic signed [31:0] src_x_i,
  input  logic signed [31:0] src_y_i,
  input  logic signed [31:0] src_z_i,
  input  logic [23:0]        moon_dist_i,
  input  logic [23:0]        earth_rad_i,
  input  logic [23:0]        moon_rad_i,
  output logic               vld_o,
  output logic               vis_o,
  output logic [24:0]        pos_x_o,
  output logic [24:0]        pos_y_o,
  output logic [24:0]        pos_z_o,
  output logic signed [31:0] up_x_o,
  output logic signed [31:0] up_y_o,
  output logic signed [31:0] up_z_o
);

  logic vld_r [1:GEO_LAT];

  logic signed [31:0] src_in [3];
  logic signed [63:0] m_sa_ci, m_sa_si, m_ci_ca, m_si_ca, m_cl_cx, m_cl_sx;

  // stage 1
  logic signed [31:0] uc1_r [3], mv1_r [3], upe1_r [3], src1_r [3];
  trig_t tr1_r;
  logic body1_r;
  // stage 2
  logic signed [56:0] m_cm [3];
  logic signed [32:0] nuc [3];
  logic signed [64:0] m_a [3];
  logic signed [63:0] m_b [3];
  logic signed [25:0] cm2_r [3];
  logic signed [31:0] a2_r [3], b2_r [3], upe2_r [3], src2_r [3];
  trig_t tr2_r;
  logic body2_r;
  // stage 3
  logic signed [32:0] h3_r [3];
  logic signed [25:0] cm3_r [3];
  logic signed [31:0] upe3_r [3], src3_r [3];
  trig_t tr3_r;
  logic body3_r;
  // stage 4
  logic signed [32:0] kv [3];
  logic signed [64:0] m_c [3], m_g [3];
  logic signed [32:0] c4_r [3], g4_r [3];
  logic signed [25:0] cm4_r [3];
  logic signed [31:0] upe4_r [3], src4_r [3];
  logic signed [31:0] sm4_r;
  logic body4_r;
  // stage 5
  logic signed [33:0] s5 [3];
  logic signed [31:0] up5_r [3], src5_r [3];
  logic signed [25:0] cm5_r [3];
  logic signed [31:0] sm5_r;
  logic body5_r;
  // stage 6
  logic [23:0] rad_pos;
  logic signed [56:0] m_rp [3];
  logic signed [63:0] m_dp [3];
  logic signed [25:0] rp6_r [3], cm6_r [3];
  logic signed [63:0] dp6_r [3];
  logic signed [63:0] thr6_r;
  logic signed [31:0] up6_r [3], src6_r [3];
  logic body6_r;
  // stage 7
  logic signed [63:0] dot;
  logic signed [26:0] pos7_r [3];
  logic signed [25:0] cm7_r [3];
  logic signed [31:0] up7_r [3], src7_r [3];
  logic vis7_r, body7_r;
  // stage 8
  logic signed [27:0] d8_r [3];
  logic [24:0] sat8_r [3];
  logic signed [31:0] up8_r [3], src8_r [3];
  logic vis8_r, body8_r;
  // stage 9
  logic signed [63:0] m_pp [3], m_qq [3];
  logic signed [63:0] pp9_r [3], qq9_r [3];
  logic [24:0] sat9_r [3];
  logic signed [31:0] up9_r [3];
  logic vis9_r, body9_r;
  // stage 10
  logic signed [63:0] proj;
  logic signed [33:0] pk10_r;
  logic signed [63:0] dd10_r;
  logic [24:0] sat10_r [3];
  logic signed [31:0] up10_r [3];
  logic pp10_r, vis10_r, body10_r;
  // stage 11
  logic [23:0] rad_occ;
  logic signed [63:0] pk2_11_r, dd11_r;
  logic [47:0] rr11_r;
  logic [24:0] sat11_r [3];
  logic signed [31:0] up11_r [3];
  logic pp11_r, vis11_r;
  // stage 12
  logic occ;
  logic vis12_r;
  logic [24:0] sat12_r [3];
  logic signed [31:0] up12_r [3];

  assign src_in[0] = src_x_i;
  assign src_in[1] = src_y_i;
  assign src_in[2] = src_z_i;

  assign m_sa_ci = trig_i.sa * trig_i.ci;
  assign m_sa_si = trig_i.sa * trig_i.si;
  assign m_ci_ca = trig_i.ci * trig_i.ca;
  assign m_si_ca = trig_i.si * trig_i.ca;
  assign m_cl_cx = trig_i.cl * trig_i.cx;
  assign m_cl_sx = trig_i.cl * trig_i.sx;

  assign kv[0]   = 33'sd0;
  assign kv[1]   = -33'(tr3_r.si);
  assign kv[2]   = 33'(tr3_r.ci);
  assign rad_pos = body5_r ? moon_rad_i : earth_rad_i;
  assign rad_occ = body10_r ? earth_rad_i : moon_rad_i;
  assign dot     = dp6_r[0] + dp6_r[1] + dp6_r[2];
  assign proj    = pp9_r[0] + pp9_r[1] + pp9_r[2];
  assign occ     = pp11_r && ((dd11_r - pk2_11_r) < $signed({16'b0, rr11_r}));

  for (genvar j = 0; j < 3; j++) begin : g_lane
    assign m_cm[j] = $signed({1'b0, moon_dist_i}) * uc1_r[j];
    assign nuc[j]  = -33'(uc1_r[j]);
    assign m_a[j]  = tr1_r.cx * nuc[j];
    assign m_b[j]  = tr1_r.sx * mv1_r[j];
    assign m_c[j]  = tr3_r.cl * h3_r[j];
    assign m_g[j]  = tr3_r.sl * kv[j];
    assign s5[j]   = 34'(c4_r[j]) + 34'(g4_r[j]);
    assign m_rp[j] = $signed({1'b0, rad_pos}) * up5_r[j];
    assign m_dp[j] = up5_r[j] * src5_r[j];
    assign m_pp[j] = d8_r[j] * src8_r[j];
    assign m_qq[j] = d8_r[j] * d8_r[j];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 1; i <= GEO_LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else begin
      vld_r[1] <= vld_i;
      for (int i = 2; i <= GEO_LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    uc1_r[0]  <= trig_i.ca;
    uc1_r[1]  <= m_sa_ci[61:30];
    uc1_r[2]  <= m_sa_si[61:30];
    mv1_r[0]  <= trig_i.sa;
    mv1_r[1]  <= -$signed(m_ci_ca[61:30]);
    mv1_r[2]  <= -$signed(m_si_ca[61:30]);
    upe1_r[0] <= m_cl_cx[61:30];
    upe1_r[1] <= m_cl_sx[61:30];
    upe1_r[2] <= trig_i.sl;
    tr1_r     <= trig_i;
    body1_r   <= body_i;
    tr2_r     <= tr1_r;
    body2_r   <= body1_r;
    tr3_r     <= tr2_r;
    body3_r   <= body2_r;
    sm4_r     <= tr3_r.sm;
    body4_r   <= body3_r;
    sm5_r     <= sm4_r;
    body5_r   <= body4_r;
    thr6_r    <= {{2{sm5_r[31]}}, sm5_r, 30'b0};
    body6_r   <= body5_r;
    vis7_r    <= dot >= thr6_r;
    body7_r   <= body6_r;
    vis8_r    <= vis7_r;
    body8_r   <= body7_r;
    vis9_r    <= vis8_r;
    body9_r   <= body8_r;
    pk10_r    <= proj[63:30];
    pp10_r    <= proj > 64'sd0;
    dd10_r    <= qq9_r[0] + qq9_r[1] + qq9_r[2];
    vis10_r   <= vis9_r;
    body10_r  <= body9_r;
    pk2_11_r  <= pk10_r * pk10_r;
    dd11_r    <= dd10_r;
    rr11_r    <= 48'(rad_occ) * 48'(rad_occ);
    pp11_r    <= pp10_r;
    vis11_r   <= vis10_r;
    vis12_r   <= vis11_r & ~occ;
    for (int j = 0; j < 3; j++) begin
      src1_r[j]  <= src_in[j];
      cm2_r[j]   <= m_cm[j][55:30];
      a2_r[j]    <= m_a[j][61:30];
      b2_r[j]    <= m_b[j][61:30];
      upe2_r[j]  <= clamp_q30(35'(upe1_r[j]));
      src2_r[j]  <= src1_r[j];
      h3_r[j]    <= 33'(a2_r[j]) + 33'(b2_r[j]);
      cm3_r[j]   <= cm2_r[j];
      upe3_r[j]  <= upe2_r[j];
      src3_r[j]  <= src2_r[j];
      c4_r[j]    <= m_c[j][62:30];
      g4_r[j]    <= m_g[j][62:30];
      cm4_r[j]   <= cm3_r[j];
      upe4_r[j]  <= upe3_r[j];
      src4_r[j]  <= src3_r[j];
      up5_r[j]   <= body4_r ? clamp_q30(35'(s5[j])) : upe4_r[j];
      cm5_r[j]   <= cm4_r[j];
      src5_r[j]  <= src4_r[j];
      rp6_r[j]   <= m_rp[j][55:30];
      dp6_r[j]   <= m_dp[j];
      cm6_r[j]   <= cm5_r[j];
      up6_r[j]   <= up5_r[j];
      src6_r[j]  <= src5_r[j];
      pos7_r[j]  <= body6_r ? (27'(cm6_r[j]) + 27'(rp6_r[j])) : 27'(rp6_r[j]);
      cm7_r[j]   <= cm6_r[j];
      up7_r[j]   <= up6_r[j];
      src7_r[j]  <= src6_r[j];
      d8_r[j]    <= (body7_r ? 28'sd0 : 28'(cm7_r[j])) - 28'(pos7_r[j]);
      sat8_r[j]  <= sat_pos(pos7_r[j]);
      up8_r[j]   <= up7_r[j];
      src8_r[j]  <= src7_r[j];
      pp9_r[j]   <= m_pp[j];
      qq9_r[j]   <= m_qq[j];
      sat9_r[j]  <= sat8_r[j];
      up9_r[j]   <= up8_r[j];
      sat10_r[j] <= sat9_r[j];
      up10_r[j]  <= up9_r[j];
      sat11_r[j] <= sat10_r[j];
      up11_r[j]  <= up10_r[j];
      sat12_r[j] <= sat11_r[j];
      up12_r[j]  <= up11_r[j];
    end
  end

  assign vld_o   = vld_r[GEO_LAT];
  assign vis_o   = vis12_r;
  assign pos_x_o = sat12_r[0];
  assign pos_y_o = sat12_r[1];
  assign pos_z_o = sat12_r[2];
  assign up_x_o  = up12_r[0];
  assign up_y_o  = up12_r[1];
  assign up_z_o  = up12_r[2];

`ifndef SYNTHESIS
  a_vld_latency: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[GEO_LAT] |-> $past(vld_i, GEO_LAT))
    else $error("geo beat without matching input");

  a_vis_needs_elev: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[GEO_LAT] && vis12_r) |-> $past(vis7_r, 5))
    else $error("visible beat failed elevation");

  a_up_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[5] |-> ((35'(up5_r[0]) <= Q30_POS) && (35'(up5_r[0]) >= Q30_NEG) &&
                  (35'(up5_r[2]) <= Q30_POS) && (35'(up5_r[2]) >= Q30_NEG)))
    else $error("up vector out of range");
`endif

endmodule

/* hdl/station_visibility_geometry.sv */
// Path: a beat taken at an edge with start high and busy low passes the front
// end, the sine units and the vector pipeline to the out_ ports with out_strobe.
// Throughput: one beat per cycle while busy is low; nine sine units run fully pipelined.
// Reset: synchronous active-low rst_n clears all valid bits, loads register
// defaults and holds busy high until a clock edge samples rst_n high.
// The receiver cannot stall; every out_strobe beat is taken as it appears.
// ---------------------------------------------------------------------------
// station_visibility_geometry
// Station position, up vector and source visibility for Earth or Moon
// stations: phase front end, sine units and vector pipeline.
// ---------------------------------------------------------------------------
module station_visibility_geometry import svg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_station_body,
  input  logic signed [31:0]   in_station_lat,
  input  logic [31:0]          in_station_lon,
  input  logic signed [31:0]   in_source_x,
  input  logic signed [31:0]   in_source_y,
  input  logic signed [31:0]   in_source_z,
  input  logic [31:0]          in_time_now,
  output logic                 out_strobe,
  output logic                 out_visible,
  output logic signed [24:0]   out_pos_x,
  output logic signed [24:0]   out_pos_y,
  output logic signed [24:0]   out_pos_z,
  output logic signed [31:0]   out_up_x,
  output logic signed [31:0]   out_up_y,
  output logic signed [31:0]   out_up_z,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  localparam int A_SA = 0;
  localparam int A_CA = 1;
  localparam int A_SI = 2;
  localparam int A_CI = 3;
  localparam int A_SL = 4;
  localparam int A_CL = 5;
  localparam int A_SX = 6;
  localparam int A_CX = 7;
  localparam int A_SM = 8;

  logic busy_r;
  logic accept;

  logic [31:0] moon_inc_r, moon_phase_r, moon_rate_r, earth_rate_r, min_elev_r;
  logic [23:0] moon_dist_r, earth_rad_r, moon_rad_r;

  logic vld0_r, vld1_r, vld2_r;
  logic body0_r, body1_r, body2_r;
  logic [31:0] lat0_r, lon0_r, time0_r, lat1_r, lon1_r;
  logic signed [31:0] src0_r [3], src1_r [3], src2_r [3];
  logic [63:0] mr_p1_r, er_p1_r;
  logic [31:0] ma, th, xa;
  logic [31:0] ang_r [NUM_ANG];
  logic signed [31:0] sin_y [NUM_ANG];

  logic vld_d [SIN_LAT];
  logic body_d [SIN_LAT];
  logic signed [31:0] src_d [SIN_LAT][3];

  trig_t trig;

  assign accept    = start & ~busy_r;
  assign busy      = busy_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b1;
      moon_inc_r   <= RST_MOON_INC;
      moon_phase_r <= RST_MOON_PHASE;
      moon_rate_r  <= RST_MOON_RATE;
      earth_rate_r <= RST_EARTH_RATE;
      moon_dist_r  <= RST_MOON_DIST;
      earth_rad_r  <= RST_EARTH_RAD;
      moon_rad_r   <= RST_MOON_RAD;
      min_elev_r   <= RST_MIN_ELEV;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MOON_INC:   moon_inc_r   <= cfg_data;
          REG_MOON_PHASE: moon_phase_r <= cfg_data;
          REG_MOON_RATE:  moon_rate_r  <= cfg_data;
          REG_EARTH_RATE: earth_rate_r <= cfg_data;
          REG_MOON_DIST:  moon_dist_r  <= cfg_data[23:0];
          REG_EARTH_RAD:  earth_rad_r  <= cfg_data[23:0];
          REG_MOON_RAD:   moon_rad_r   <= cfg_data[23:0];
          REG_MIN_ELEV:   min_elev_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      for (int i = 0; i < SIN_LAT; i++) begin
        vld_d[i] <= 1'b0;
      end
    end else begin
      vld0_r   <= accept;
      vld1_r   <= vld0_r;
      vld2_r   <= vld1_r;
      vld_d[0] <= vld2_r;
      for (int i = 1; i < SIN_LAT; i++) begin
        vld_d[i] <= vld_d[i-1];
      end
    end
  end

  assign ma = moon_phase_r + mr_p1_r[47:16];
  assign th = lon1_r + er_p1_r[47:16];
  assign xa = body1_r ? lon1_r : th;

  always_ff @(posedge clk) begin
    body0_r   <= in_station_body;
    lat0_r    <= in_station_lat;
    lon0_r    <= in_station_lon;
    time0_r   <= in_time_now;
    src0_r[0] <= in_source_x;
    src0_r[1] <= in_source_y;
    src0_r[2] <= in_source_z;
    mr_p1_r   <= 64'(moon_rate_r) * 64'(time0_r);
    er_p1_r   <= 64'(earth_rate_r) * 64'(time0_r);
    lat1_r    <= lat0_r;
    lon1_r    <= lon0_r;
    body1_r   <= body0_r;
    body2_r   <= body1_r;
    ang_r[A_SA] <= ma;
    ang_r[A_CA] <= ma + QTR_TURN;
    ang_r[A_SI] <= moon_inc_r;
    ang_r[A_CI] <= moon_inc_r + QTR_TURN;
    ang_r[A_SL] <= lat1_r;
    ang_r[A_CL] <= lat1_r + QTR_TURN;
    ang_r[A_SX] <= xa;
    ang_r[A_CX] <= xa + QTR_TURN;
    ang_r[A_SM] <= min_elev_r;
    body_d[0] <= body2_r;
    for (int j = 0; j < 3; j++) begin
      src1_r[j]   <= src0_r[j];
      src2_r[j]   <= src1_r[j];
      src_d[0][j] <= src2_r[j];
    end
    for (int i = 1; i < SIN_LAT; i++) begin
      body_d[i] <= body_d[i-1];
      for (int j = 0; j < 3; j++) begin
        src_d[i][j] <= src_d[i-1][j];
      end
    end
  end

  for (genvar g = 0; g < NUM_ANG; g++) begin : g_sin
    svg_sin u_sin (
      .clk   (clk),
      .ang_i (ang_r[g]),
      .y_o   (sin_y[g])
    );
  end

  assign trig.ca = sin_y[A_CA];
  assign trig.sa = sin_y[A_SA];
  assign trig.ci = sin_y[A_CI];
  assign trig.si = sin_y[A_SI];
  assign trig.cl = sin_y[A_CL];
  assign trig.sl = sin_y[A_SL];
  assign trig.cx = sin_y[A_CX];
  assign trig.sx = sin_y[A_SX];
  assign trig.sm = sin_y[A_SM];

  svg_geo u_geo (
    .clk         (clk),
    .rst_n       (rst_n),
    .vld_i       (vld_d[SIN_LAT-1]),
    .trig_i      (trig),
    .body_i      (body_d[SIN_LAT-1]),
    .src_x_i     (src_d[SIN_LAT-1][0]),
    .src_y_i     (src_d[SIN_LAT-1][1]),
    .src_z_i     (src_d[SIN_LAT-1][2]),
    .moon_dist_i (moon_dist_r),
    .earth_rad_i (earth_rad_r),
    .moon_rad_i  (moon_rad_r),
    .vld_o       (out_strobe),
    .vis_o       (out_visible),
    .pos_x_o     (out_pos_x),
    .pos_y_o     (out_pos_y),
    .pos_z_o     (out_pos_z),
    .up_x_o      (out_up_x),
    .up_y_o      (out_up_y),
    .up_z_o      (out_up_z)
  );

`ifndef SYNTHESIS
  a_strobe_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, TOTAL_LAT))
    else $error("result beat without accepted input");

  a_busy_released: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy held after reset release");

  a_strobe_known: assert property (@(posedge clk) disable iff (!rst_n)
    !$isunknown(out_strobe))
    else $error("result strobe unknown");
`endif

endmodule

/* verif/svg_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// svg_checker
// Watches the input, result and register channels of the station visibility
// block, predicts position, up vector and visibility for every accepted beat
// and compares each result beat, field by field, with the oldest prediction.
// ---------------------------------------------------------------------------
module svg_checker import svg_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 in_station_body,
  input  logic signed [31:0]   in_station_lat,
  input  logic [31:0]          in_station_lon,
  input  logic signed [31:0]   in_source_x,
  input  logic signed [31:0]   in_source_y,
  input  logic signed [31:0]   in_source_z,
  input  logic [31:0]          in_time_now,
  input  logic                 out_strobe,
  input  logic                 out_visible,
  input  logic signed [24:0]   out_pos_x,
  input  logic signed [24:0]   out_pos_y,
  input  logic signed [24:0]   out_pos_z,
  input  logic signed [31:0]   out_up_x,
  input  logic signed [31:0]   out_up_y,
  input  logic signed [31:0]   out_up_z,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   fail_count,
  output int                   pending,
  output int                   visible_count
);

  typedef struct {
    logic               vis;
    logic signed [24:0] pos [3];
    logic signed [31:0] up [3];
  } geom_t;

  localparam longint ONE = 64'sd1073741824;

  logic [31:0] inclination, phase0, moon_rate, earth_rate, min_elev;
  logic [23:0] moon_dist, earth_rad, moon_rad;
  geom_t       geom_q [$];

  function automatic longint mulq(input longint a, input longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic longint clampl(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint quarter_sine(input logic [31:0] r);
    longint unsigned t, u, p;
    t = (longint'(r) * 64'd3373259426) >> 31;
    u = (t * t) >> 30;
    p = ONE;
    for (int i = 0; i < SIN_STEPS; i++) p = ONE - ((u * p) >> 30) / SIN_DIV[i];
    p = (t * p) >> 30;
    if (p > ONE) p = ONE;
    return longint'(p);
  endfunction

  function automatic longint sine(input logic [31:0] a);
    longint v;
    v = a[30] ? quarter_sine(32'h4000_0000 - {2'b00, a[29:0]}) : quarter_sine({2'b00, a[29:0]});
    return a[31] ? -v : v;
  endfunction

  function automatic longint cosine(input logic [31:0] a);
    return sine(a + 32'h4000_0000);
  endfunction

  function automatic geom_t station_geometry(input logic body, input logic [31:0] lat,
      input logic [31:0] lon, input logic signed [31:0] sx, input logic signed [31:0] sy,
      input logic signed [31:0] sz, input logic [31:0] tm);
    geom_t  g;
    logic [31:0] ma, th;
    longint ca, sa, ci, si, cl, sl, ct, st, h, dot, proj, rad, pk, dd;
    longint uc [3], cm [3], up [3], pos [3], ctr [3], d [3], mv [3], kv [3], src [3];
    src[0] = sx;
    src[1] = sy;
    src[2] = sz;
    ma = phase0 + 32'((longint'(moon_rate) * longint'(tm)) >> 16);
    ca = cosine(ma);
    sa = sine(ma);
    ci = cosine(inclination);
    si = sine(inclination);
    uc[0] = ca;
    uc[1] = mulq(sa, ci);
    uc[2] = mulq(sa, si);
    for (int j = 0; j < 3; j++) cm[j] = mulq(longint'(moon_dist), uc[j]);
    cl = cosine(lat);
    sl = sine(lat);
    if (!body) begin
      th = lon + 32'((longint'(earth_rate) * longint'(tm)) >> 16);
      ct = cosine(th);
      st = sine(th);
      up[0] = mulq(cl, ct);
      up[1] = mulq(cl, st);
      up[2] = sl;
      for (int j = 0; j < 3; j++) begin
        up[j] = clampl(up[j], -ONE, ONE);
        pos[j] = mulq(longint'(earth_rad), up[j]);
        ctr[j] = cm[j];
      end
      rad = moon_rad;
    end else begin
      mv[0] = sa;
      mv[1] = -mulq(ci, ca);
      mv[2] = -mulq(si, ca);
      kv[0] = 0;
      kv[1] = -si;
      kv[2] = ci;
      for (int j = 0; j < 3; j++) begin
        h = mulq(cosine(lon), -uc[j]) + mulq(sine(lon), mv[j]);
        up[j] = clampl(mulq(cl, h) + mulq(sl, kv[j]), -ONE, ONE);
        pos[j] = cm[j] + mulq(longint'(moon_rad), up[j]);
        ctr[j] = 0;
      end
      rad = earth_rad;
    end
    dot = 0;
    for (int j = 0; j < 3; j++) dot += up[j] * src[j];
    g.vis = dot >= sine(min_elev) * ONE;
    if (g.vis) begin
      proj = 0;
      for (int j = 0; j < 3; j++) begin
        d[j] = ctr[j] - pos[j];
        proj += d[j] * src[j];
      end
      if (proj > 0) begin
        pk = proj >>> 30;
        dd = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
        if (dd - pk * pk < rad * rad) g.vis = 1'b0;
      end
    end
    for (int j = 0; j < 3; j++) begin
      g.pos[j] = 25'(clampl(pos[j], -64'sd16777216, 64'sd16777215));
      g.up[j] = 32'(up[j]);
    end
    return g;
  endfunction

  function automatic int field_check(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  assign pending = geom_q.size();

  always @(posedge clk) begin
    geom_t g;
    int    bad;
    if (!rst_n) begin
      inclination <= RST_MOON_INC;
      phase0      <= RST_MOON_PHASE;
      moon_rate   <= RST_MOON_RATE;
      earth_rate  <= RST_EARTH_RATE;
      moon_dist   <= RST_MOON_DIST;
      earth_rad   <= RST_EARTH_RAD;
      moon_rad    <= RST_MOON_RAD;
      min_elev    <= RST_MIN_ELEV;
      fail_count  <= 0;
      visible_count <= 0;
      geom_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MOON_INC:   inclination <= cfg_data;
          REG_MOON_PHASE: phase0      <= cfg_data;
          REG_MOON_RATE:  moon_rate   <= cfg_data;
          REG_EARTH_RATE: earth_rate  <= cfg_data;
          REG_MOON_DIST:  moon_dist   <= cfg_data[23:0];
          REG_EARTH_RAD:  earth_rad   <= cfg_data[23:0];
          REG_MOON_RAD:   moon_rad    <= cfg_data[23:0];
          REG_MIN_ELEV:   min_elev    <= cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        geom_q.push_back(station_geometry(in_station_body, in_station_lat, in_station_lon,
                                          in_source_x, in_source_y, in_source_z, in_time_now));
      end
      if (out_strobe) begin
        if (geom_q.size() == 0) begin
          $error("result beat with no prediction waiting");
          fail_count <= fail_count + 1;
        end else begin
          g = geom_q.pop_front();
          bad = field_check("visible", g.vis, out_visible)
              + field_check("pos_x", g.pos[0], out_pos_x)
              + field_check("pos_y", g.pos[1], out_pos_y)
              + field_check("pos_z", g.pos[2], out_pos_z)
              + field_check("up_x", g.up[0], out_up_x)
              + field_check("up_y", g.up[1], out_up_y)
              + field_check("up_z", g.up[2], out_up_z);
          if (bad != 0) fail_count <= fail_count + 1;
          if (out_visible) visible_count <= visible_count + 1;
        end
      end
    end
  end

endmodule

/* verif/tb_station_visibility_geometry.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_station_visibility_geometry
// Drives directed and random station/source/time beats through the block
// under several register settings, extremes included, with random start
// gaps; a separate checker predicts and compares every result beat.
// ---------------------------------------------------------------------------
module tb_station_visibility_geometry;
  import svg_pkg::*;

  typedef logic bool_t;

  localparam int     LATENCY = TOTAL_LAT + 8;
  localparam longint LIMIT   = 200000;

  logic                 clk, rst_n, start, busy;
  logic                 in_station_body;
  logic signed [31:0]   in_station_lat, in_source_x, in_source_y, in_source_z;
  logic [31:0]          in_station_lon, in_time_now;
  logic                 out_strobe, out_visible;
  logic signed [24:0]   out_pos_x, out_pos_y, out_pos_z;
  logic signed [31:0]   out_up_x, out_up_y, out_up_z;
  logic                 cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;
  int                   fail_count, pending, visible_count;
  int                   beats_sent;
  longint               cycles;
  bool_t                calm;

  station_visibility_geometry DUT (.*);
  svg_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[station_visibility_geometry] ERROR");
      $finish;
    end
  end

  task automatic send_beat(input logic body, input logic [31:0] lat, input logic [31:0] lon,
      input logic [31:0] sx, input logic [31:0] sy, input logic [31:0] sz,
      input logic [31:0] tm);
    if (!calm && $urandom_range(0, 99) < 9) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_station_body <= body;
    in_station_lat  <= lat;
    in_station_lon  <= lon;
    in_source_x     <= sx;
    in_source_y     <= sy;
    in_source_z     <= sz;
    in_time_now     <= tm;
    start           <= 1'b1;
    do @(negedge clk); while (busy);
    @(posedge clk);
    beats_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic load_regs(input logic [31:0] v [8]);
    drain();
    write_reg(REG_MOON_INC, v[0]);
    write_reg(REG_MOON_PHASE, v[1]);
    write_reg(REG_MOON_RATE, v[2]);
    write_reg(REG_EARTH_RATE, v[3]);
    write_reg(REG_MOON_DIST, v[4]);
    write_reg(REG_EARTH_RAD, v[5]);
    write_reg(REG_MOON_RAD, v[6]);
    write_reg(REG_MIN_ELEV, v[7]);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_beat;
    real th, z, r;
    logic [31:0] lat, sx, sy, sz;
    lat = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
    if ($urandom_range(0, 9) == 0) lat = $urandom;
    if ($urandom_range(0, 9) < 7) begin
      th = $urandom * 6.283185307179586 / 4294967296.0;
      z  = ($urandom_range(0, 2000) - 1000.0) / 1000.0;
      r  = $sqrt(1.0 - z * z);
      sx = $rtoi(r * $cos(th) * 1073741824.0);
      sy = $rtoi(r * $sin(th) * 1073741824.0);
      sz = $rtoi(z * 1073741824.0);
    end else begin
      sx = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
      sy = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
      sz = $urandom_range(0, 32'h8000_0000) - 32'h4000_0000;
    end
    send_beat(1'($urandom_range(0, 1)), lat, $urandom, sx, sy, sz, $urandom);
  endtask

  initial begin
    logic [31:0] regs [8];
    cycles = 0;
    beats_sent = 0;
    calm = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_station_body = 1'b0;
    in_station_lat = '0;
    in_station_lon = '0;
    in_source_x = '0;
    in_source_y = '0;
    in_source_z = '0;
    in_time_now = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (int b = 0; b < 2; b++) begin
      send_beat(1'(b), 0, 0, 32'h4000_0000, 0, 0, 0);
      send_beat(1'(b), 32'h4000_0000, 32'hFFFF_FFFF, 0, 0, 32'h4000_0000, 32'hFFFF_FFFF);
      send_beat(1'(b), 32'hC000_0000, 32'h8000_0000, 0, 0, 32'hC000_0000, 32'h1234_5678);
      send_beat(1'(b), 32'h8000_0000, 32'h4000_0000, 0, 32'hC000_0000, 0, 32'h0001_0000);
      send_beat(1'(b), 32'h7FFF_FFFF, 32'hC000_0000, 32'hC000_0000, 0, 0, 32'h8000_0000);
      send_beat(1'(b), 0, 0, 0, 0, 0, 32'h00FF_0000);
      send_beat(1'(b), 32'h1000_0000, 32'h2000_0000, 32'h4000_0000, 32'h4000_0000,
                32'h4000_0000, 32'h0040_0000);
      send_beat(1'(b), 32'hF000_0000, 32'hA000_0000, 32'hC000_0000, 32'hC000_0000,
                32'hC000_0000, 32'h7FFF_FFFF);
    end
    for (int i = 0; i < 80; i++) begin
      calm = (i >= 30 && i < 70);
      random_beat();
    end
    calm = 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: regs = '{32'h4000_0000, 0, 0, 0, 0, 0, 0, 32'hC000_0000};
        1: regs = '{32'hC000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'h00FF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h4000_0000};
        2: regs = '{RST_MOON_INC, 32'h8000_0000, RST_MOON_RATE, RST_EARTH_RATE,
                    200000, 100000, 90000, 32'h0200_0000};
        3: regs = '{$urandom, $urandom, $urandom, $urandom, $urandom & 32'hFF_FFFF,
                    $urandom & 32'hFF_FFFF, $urandom & 32'hFF_FFFF, $urandom};
        4: regs = '{32'h1000_0000, 32'h4000_0000, 32'h0001_0000, 32'h0100_0000,
                    32'h0000_8000, 32'h0000_4000, 32'h0000_4000, 32'hF000_0000};
        default: regs = '{RST_MOON_INC, RST_MOON_PHASE, RST_MOON_RATE, RST_EARTH_RATE,
                          RST_MOON_DIST, RST_EARTH_RAD, RST_MOON_RAD, RST_MIN_ELEV};
      endcase
      load_regs(regs);
      for (int i = 0; i < 62; i++) random_beat();
    end

    drain();
    $display("Sent %0d beats over seven register settings, extremes included;", beats_sent);
    $display("%0d results came back visible.", visible_count);
    if (fail_count == 0) begin
      $display("[station_visibility_geometry] OK");
    end else begin
      $display("[station_visibility_geometry] ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
hdl/svg_pkg.sv
hdl/svg_sin_step.sv
hdl/svg_sin.sv
hdl/svg_geo.sv
hdl/station_visibility_geometry.sv
verif/svg_checker.sv
verif/tb_station_visibility_geometry.sv
